// ----- hw/rtl/firmware_packet_receiver_defines.svh -----
// Assertion macros used by the port-level checker file.
`ifndef FIRMWARE_PACKET_RECEIVER_DEFINES_SVH
`define FIRMWARE_PACKET_RECEIVER_DEFINES_SVH
// Assert that an implication holds at each clock edge outside reset.
`define FPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition holds in the cycle after another.
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/fpr_pkg.sv -----
// Types, codes and CRC functions of the firmware packet receiver.
package fpr_pkg;

  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_READY     = 4'd1,
    ST_SIZE_OK   = 4'd2,
    ST_SIZE_ERR  = 4'd3,
    ST_ACK       = 4'd4,
    ST_NACK      = 4'd5,
    ST_DONE      = 4'd6,
    ST_CRC_ERR   = 4'd7,
    ST_RETRY_ERR = 4'd8,
    ST_WORD_TO   = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    REG_MAX_IMAGE   = 3'd0,
    REG_MAX_PACKET  = 3'd1,
    REG_MAX_ATTEMPT = 3'd2,
    REG_PKT_TIMEOUT = 3'd3,
    REG_WORD_TIMEOUT = 3'd4,
    REG_MAGIC       = 3'd5
  } reg_e;

  typedef struct packed {
    logic [23:0] max_image;
    logic [15:0] max_packet;
    logic [3:0]  max_attempts;
    logic [15:0] pkt_timeout;
    logic [15:0] word_timeout;
    logic [31:0] magic;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        data_valid;
    logic [7:0]  data_out;
    logic [23:0] data_address;
    logic [23:0] commit_offset;
    logic [15:0] commit_length;
  } out_t;

  // CRC16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // CRC-32 reflected, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/fpr_stream_if.sv -----
// Valid/ready channel carrying one payload.
interface fpr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/fpr_cfg_regs.sv -----
// Configuration register file.
module fpr_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fpr_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [fpr_pkg::CfgWidth-1:0]       cfg_data_i,
  output fpr_pkg::cfg_t                      cfg_o
);
  fpr_pkg::cfg_t cfg_q;

  // register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_image    <= 24'd917504;
      cfg_q.max_packet   <= 16'd1024;
      cfg_q.max_attempts <= 4'd5;
      cfg_q.pkt_timeout  <= 16'd3000;
      cfg_q.word_timeout <= 16'd5000;
      cfg_q.magic        <= 32'hA55A1234;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpr_pkg::REG_MAX_IMAGE:    cfg_q.max_image    <= cfg_data_i[23:0];
        fpr_pkg::REG_MAX_PACKET:   cfg_q.max_packet   <= cfg_data_i[15:0];
        fpr_pkg::REG_MAX_ATTEMPT:  cfg_q.max_attempts <= cfg_data_i[3:0];
        fpr_pkg::REG_PKT_TIMEOUT:  cfg_q.pkt_timeout  <= cfg_data_i[15:0];
        fpr_pkg::REG_WORD_TIMEOUT: cfg_q.word_timeout <= cfg_data_i[15:0];
        fpr_pkg::REG_MAGIC:        cfg_q.magic        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- hw/rtl/fpr_core.sv -----
// Session state machine: one request per cycle while step_i is high, one result per request.
module fpr_core #(
  parameter int unsigned OFFSET_WIDTH = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  fpr_pkg::in_t  in_i,
  input  fpr_pkg::cfg_t cfg_i,
  output fpr_pkg::out_t out_o
);
  typedef enum logic [2:0] {
    PH_IDLE, PH_SIZE, PH_CRC, PH_HEADER, PH_PAYLOAD
  } phase_e;

  phase_e phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d, tick_q, tick_d;
  logic [31:0] hmagic_q, hmagic_d, hseq_q, hseq_d, hofs_q, hofs_d;
  logic [15:0] hlen_q, hlen_d, hchk_q, hchk_d, pchk_q, pchk_d, crc16_q, crc16_d;
  logic [31:0] crc_com_q, crc_com_d, crc_ten_q, crc_ten_d;
  logic [31:0] size_q, size_d, exp_q, exp_d, nseq_q, nseq_d;
  logic [OFFSET_WIDTH-1:0] rcvd_q, rcvd_d;
  logic [3:0]  att_q, att_d;
  fpr_pkg::out_t out_d;

  logic [7:0]  b;
  logic [4:0]  sh;
  logic [31:0] bw;
  logic [15:0] cnt_inc, tick_inc, hbyte, limit_w, new_crc16;
  logic [3:0]  att_inc, att_lim;
  logic [31:0] remain, rcvd_ext, rcvd_sum, new_crc32;
  logic        fail_now, hdr_bad;

  always_comb begin
    b        = in_i.rx_byte;
    sh       = {cnt_q[1:0], 3'b000};
    bw       = {24'd0, b} << sh;
    hbyte    = {8'd0, b} << {cnt_q[0], 3'b000};
    cnt_inc  = cnt_q + 16'd1;
    tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
    att_inc  = att_q + 4'd1;
    att_lim  = (cfg_i.max_attempts != 4'd0) ? cfg_i.max_attempts : 4'd1;
    rcvd_ext = 32'(rcvd_q);
    remain   = (size_q >= rcvd_ext) ? size_q - rcvd_ext : 32'd0;
    rcvd_sum = 32'(OFFSET_WIDTH'(rcvd_ext + {16'd0, hlen_q}));
    new_crc16 = fpr_pkg::crc16_byte(crc16_q,
        (cnt_q == 16'd14 || cnt_q == 16'd15) ? 8'd0 : b);
    new_crc32 = fpr_pkg::crc32_byte(crc_ten_q, b);
    limit_w  = 16'd0;
    fail_now = 1'b0;
    hdr_bad  = 1'b0;

    phase_d = phase_q; cnt_d = cnt_q; tick_d = tick_q;
    hmagic_d = hmagic_q; hseq_d = hseq_q; hofs_d = hofs_q; hlen_d = hlen_q;
    hchk_d = hchk_q; pchk_d = pchk_q; crc16_d = crc16_q;
    crc_com_d = crc_com_q; crc_ten_d = crc_ten_q; size_d = size_q; exp_d = exp_q;
    rcvd_d = rcvd_q; nseq_d = nseq_q; att_d = att_q;
    out_d = '0;

    case (in_i.kind)
      fpr_pkg::KIND_START: begin
        phase_d = PH_SIZE; cnt_d = '0; tick_d = '0;
        hmagic_d = '0; hseq_d = '0; hofs_d = '0; hlen_d = '0;
        hchk_d = '0; pchk_d = '0; crc16_d = 16'hFFFF;
        crc_com_d = '1; crc_ten_d = '1; size_d = '0; exp_d = '0;
        rcvd_d = '0; nseq_d = '0; att_d = '0;
        out_d.status = fpr_pkg::ST_READY;
      end
      fpr_pkg::KIND_TICK: begin
        if (phase_q == PH_SIZE || phase_q == PH_CRC) begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.word_timeout) begin
            phase_d = PH_IDLE;
            out_d.status = fpr_pkg::ST_WORD_TO;
          end
        end else if (phase_q == PH_HEADER || phase_q == PH_PAYLOAD) begin
          tick_d = tick_inc;
          limit_w = cfg_i.pkt_timeout;
          fail_now = (tick_inc >= limit_w);
        end
      end
      fpr_pkg::KIND_BYTE: begin
        case (phase_q)
          PH_SIZE: begin
            size_d = size_q | bw;
            cnt_d = cnt_inc;
            if (cnt_inc >= 16'd4) begin
              phase_d = PH_CRC; cnt_d = '0; tick_d = '0;
            end
          end
          PH_CRC: begin
            exp_d = exp_q | bw;
            cnt_d = cnt_inc;
            if (cnt_inc >= 16'd4) begin
              if (size_q == 32'd0 || size_q > {8'd0, cfg_i.max_image}) begin
                phase_d = PH_IDLE;
                out_d.status = fpr_pkg::ST_SIZE_ERR;
              end else begin
                phase_d = PH_HEADER; cnt_d = '0; tick_d = '0; crc16_d = 16'hFFFF;
                hmagic_d = '0; hseq_d = '0; hofs_d = '0; hlen_d = '0;
                hchk_d = '0; pchk_d = '0;
                out_d.status = fpr_pkg::ST_SIZE_OK;
              end
            end
          end
          PH_HEADER: begin
            if (cnt_q < 16'd4)       hmagic_d = hmagic_q | bw;
            else if (cnt_q < 16'd8)  hseq_d = hseq_q | bw;
            else if (cnt_q < 16'd12) hofs_d = hofs_q | bw;
            else if (cnt_q < 16'd14) hlen_d = hlen_q | hbyte;
            else if (cnt_q < 16'd16) hchk_d = hchk_q | hbyte;
            else if (cnt_q < 16'd18) pchk_d = pchk_q | hbyte;
            crc16_d = new_crc16;
            cnt_d = cnt_inc;
            if (cnt_inc >= 16'd20) begin
              hdr_bad = (hmagic_q != cfg_i.magic) || (hchk_q != new_crc16) ||
                        (hseq_q != nseq_q) || (hofs_q != rcvd_ext) ||
                        (hlen_q == 16'd0) || (hlen_q > cfg_i.max_packet) ||
                        ({16'd0, hlen_q} > remain);
              if (hdr_bad) begin
                fail_now = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD; cnt_d = '0; tick_d = '0;
                crc16_d = 16'hFFFF; crc_ten_d = crc_com_q;
              end
            end
          end
          PH_PAYLOAD: begin
            out_d.data_valid = 1'b1;
            out_d.data_out = b;
            out_d.data_address = 24'(hofs_q + {16'd0, cnt_q});
            crc16_d = fpr_pkg::crc16_byte(crc16_q, b);
            crc_ten_d = new_crc32;
            cnt_d = cnt_inc;
            if (cnt_inc >= hlen_q) begin
              if (crc16_d != pchk_q) begin
                fail_now = 1'b1;
              end else begin
                crc_com_d = new_crc32;
                rcvd_d = OFFSET_WIDTH'(rcvd_sum);
                nseq_d = nseq_q + 32'd1;
                att_d = '0;
                out_d.commit_offset = hofs_q[23:0];
                out_d.commit_length = hlen_q;
                if (rcvd_sum == size_q) begin
                  phase_d = PH_IDLE;
                  out_d.status = (~new_crc32 == exp_q) ? fpr_pkg::ST_DONE
                                                       : fpr_pkg::ST_CRC_ERR;
                end else begin
                  phase_d = PH_HEADER; cnt_d = '0; tick_d = '0; crc16_d = 16'hFFFF;
                  hmagic_d = '0; hseq_d = '0; hofs_d = '0; hlen_d = '0;
                  hchk_d = '0; pchk_d = '0;
                  out_d.status = fpr_pkg::ST_ACK;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // failed attempt: retry the header or give up
    if (fail_now) begin
      att_d = att_inc;
      if (att_inc >= att_lim) begin
        phase_d = PH_IDLE;
        out_d.status = fpr_pkg::ST_RETRY_ERR;
      end else begin
        phase_d = PH_HEADER; cnt_d = '0; tick_d = '0; crc16_d = 16'hFFFF;
        hmagic_d = '0; hseq_d = '0; hofs_d = '0; hlen_d = '0;
        hchk_d = '0; pchk_d = '0;
        out_d.status = fpr_pkg::ST_NACK;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cnt_q <= '0; tick_q <= '0;
      hmagic_q <= '0; hseq_q <= '0; hofs_q <= '0; hlen_q <= '0;
      hchk_q <= '0; pchk_q <= '0; crc16_q <= 16'hFFFF;
      crc_com_q <= '1; crc_ten_q <= '1; size_q <= '0; exp_q <= '0;
      rcvd_q <= '0; nseq_q <= '0; att_q <= '0;
      out_o <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; tick_q <= tick_d;
      hmagic_q <= hmagic_d; hseq_q <= hseq_d; hofs_q <= hofs_d; hlen_q <= hlen_d;
      hchk_q <= hchk_d; pchk_q <= pchk_d; crc16_q <= crc16_d;
      crc_com_q <= crc_com_d; crc_ten_q <= crc_ten_d; size_q <= size_d;
      exp_q <= exp_d; rcvd_q <= rcvd_d; nseq_q <= nseq_d; att_q <= att_d;
      out_o <= out_d;
    end
  end
endmodule

// ----- hw/rtl/firmware_packet_receiver.sv -----
// Top level of the firmware packet receiver.
// One result per request; a request is taken every cycle while the result
// register is empty or being drained, so the sustained rate is one request per
// clock. The result and the CRC updates for a byte are registered together.
// Configuration is to be written while idle; the block does not enforce this.
module firmware_packet_receiver #(
  parameter int unsigned OFFSET_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [fpr_pkg::CfgWidth-1:0]    cfg_data_i,
  fpr_stream_if.sink                      in_if,
  fpr_stream_if.source                    out_if
);
  fpr_pkg::cfg_t cfg;
  fpr_pkg::in_t  req;
  logic          full_q, step;

  assign req.kind    = in_if.payload.kind;
  assign req.rx_byte = in_if.payload.rx_byte;

  assign in_if.ready = !full_q || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (step) begin
      full_q <= 1'b1;
    end else if (out_if.ready) begin
      full_q <= 1'b0;
    end
  end
  assign out_if.valid = full_q;

  fpr_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  fpr_core #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
    .clk_i, .rst_ni, .step_i(step), .in_i(req), .cfg_i(cfg), .out_o(out_if.payload)
  );
endmodule

// ----- hw/rtl/fpr_checker.sv -----
// Port-level checker for the firmware packet receiver, bound to the top level.
`include "firmware_packet_receiver_defines.svh"
module fpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid,
  input logic          in_ready,
  input fpr_pkg::in_t  in_pl,
  input logic          out_valid,
  input logic          out_ready,
  input fpr_pkg::out_t out_pl
);
  `FPR_ASSERT_NEXT(a_start_ready, clk_i, rst_ni,
    in_valid && in_ready && in_pl.kind == fpr_pkg::KIND_START,
    out_valid && out_pl.status == fpr_pkg::ST_READY, "start not answered ready")
  `FPR_ASSERT_NEXT(a_accept_valid, clk_i, rst_ni, in_valid && in_ready,
    out_valid, "result missing after request")
  `FPR_ASSERT_IMPL(a_no_data_idle, clk_i, rst_ni, out_valid && !out_pl.data_valid,
    out_pl.data_out == 8'd0 && out_pl.data_address == 24'd0, "stray data fields")
  `FPR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(out_pl), "stalled result changed")
endmodule

bind firmware_packet_receiver fpr_checker u_fpr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_pl(req),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_pl(out_if.payload)
);

// ----- dv/fpr_rx_checker.sv -----
// Checker: watches the request and result channels, predicts each result and compares.
module fpr_rx_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  fpr_pkg::in_t  in_payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  fpr_pkg::out_t out_payload_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          ack_count_o,
  output int          done_count_o
);
  typedef enum logic [2:0] {
    PH_IDLE, PH_SIZE, PH_CRC, PH_HEADER, PH_PAYLOAD
  } phase_e;

  // configuration copy
  logic [23:0] max_image;
  logic [15:0] max_packet;
  logic [3:0]  max_attempts;
  logic [15:0] pkt_timeout;
  logic [15:0] word_timeout;
  logic [31:0] magic;

  // session copy
  phase_e      phase;
  logic [15:0] byte_count, hdr_length, hdr_check, pay_check, crc16_run, tick_count;
  logic [31:0] hdr_magic, hdr_seq, hdr_offset;
  logic [31:0] crc_committed, crc_tentative, image_size, image_crc, next_seq;
  logic [23:0] bytes_received;
  logic [3:0]  attempts;

  fpr_pkg::out_t expected_results[$];
  int   fails, results, acks, dones;

  assign fail_count_o   = fails;
  assign pending_o      = expected_results.size();
  assign result_count_o = results;
  assign ack_count_o    = acks;
  assign done_count_o   = dones;

  // bitwise CRC helpers written independently of the package
  function automatic logic [15:0] ccitt_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      r = (r[15] ^ b[k]) ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] ieee_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_session();
    phase = PH_IDLE;
    byte_count = 0; hdr_magic = 0; hdr_seq = 0; hdr_offset = 0;
    hdr_length = 0; hdr_check = 0; pay_check = 0; crc16_run = 16'hFFFF;
    crc_committed = '1; crc_tentative = '1; image_size = 0; image_crc = 0;
    bytes_received = 0; next_seq = 0; attempts = 0; tick_count = 0;
  endfunction

  function automatic void open_header();
    phase = PH_HEADER;
    byte_count = 0; tick_count = 0; crc16_run = 16'hFFFF;
    hdr_magic = 0; hdr_seq = 0; hdr_offset = 0;
    hdr_length = 0; hdr_check = 0; pay_check = 0;
  endfunction

  function automatic fpr_pkg::status_e fail_attempt();
    logic [3:0] lim;
    lim = (max_attempts == 0) ? 4'd1 : max_attempts;
    attempts = attempts + 4'd1;
    if (attempts >= lim) begin
      phase = PH_IDLE;
      return fpr_pkg::ST_RETRY_ERR;
    end
    open_header();
    return fpr_pkg::ST_NACK;
  endfunction

  function automatic logic tick_expired(logic [15:0] lim);
    if (tick_count != 16'hFFFF) tick_count++;
    return tick_count >= lim;
  endfunction

  // predict one result for one request
  function automatic fpr_pkg::out_t predict_result(fpr_pkg::in_t req);
    fpr_pkg::out_t r;
    logic [15:0] i;
    logic [7:0]  b;
    logic [31:0] remain;
    int sh;
    r = '0;
    b = req.rx_byte;
    i = byte_count;
    sh = 8 * i[1:0];
    case (fpr_pkg::kind_e'(req.kind))
      fpr_pkg::KIND_START: begin
        clear_session();
        phase = PH_SIZE;
        r.status = fpr_pkg::ST_READY;
      end
      fpr_pkg::KIND_TICK: begin
        if (phase == PH_SIZE || phase == PH_CRC) begin
          if (tick_expired(word_timeout)) begin
            phase = PH_IDLE;
            r.status = fpr_pkg::ST_WORD_TO;
          end
        end else if (phase == PH_HEADER || phase == PH_PAYLOAD) begin
          if (tick_expired(pkt_timeout)) r.status = fail_attempt();
        end
      end
      fpr_pkg::KIND_BYTE: begin
        case (phase)
          PH_SIZE: begin
            image_size |= 32'(b) << sh;
            byte_count = i + 1;
            if (byte_count >= 4) begin
              phase = PH_CRC; byte_count = 0; tick_count = 0;
            end
          end
          PH_CRC: begin
            image_crc |= 32'(b) << sh;
            byte_count = i + 1;
            if (byte_count >= 4) begin
              if (image_size == 0 || image_size > {8'd0, max_image}) begin
                phase = PH_IDLE;
                r.status = fpr_pkg::ST_SIZE_ERR;
              end else begin
                open_header();
                r.status = fpr_pkg::ST_SIZE_OK;
              end
            end
          end
          PH_HEADER: begin
            if (i < 4) hdr_magic |= 32'(b) << sh;
            else if (i < 8) hdr_seq |= 32'(b) << sh;
            else if (i < 12) hdr_offset |= 32'(b) << sh;
            else if (i < 14) hdr_length |= 16'(b) << (8 * i[0]);
            else if (i < 16) hdr_check |= 16'(b) << (8 * i[0]);
            else if (i < 18) pay_check |= 16'(b) << (8 * i[0]);
            crc16_run = ccitt_step(crc16_run, (i == 14 || i == 15) ? 8'd0 : b);
            byte_count = i + 1;
            if (byte_count >= 20) begin
              remain = (image_size >= {8'd0, bytes_received}) ?
                       image_size - {8'd0, bytes_received} : 0;
              if (hdr_magic != magic || hdr_check != crc16_run ||
                  hdr_seq != next_seq || hdr_offset != {8'd0, bytes_received} ||
                  hdr_length == 0 || hdr_length > max_packet ||
                  {16'd0, hdr_length} > remain) begin
                r.status = fail_attempt();
              end else begin
                phase = PH_PAYLOAD;
                byte_count = 0; tick_count = 0; crc16_run = 16'hFFFF;
                crc_tentative = crc_committed;
              end
            end
          end
          PH_PAYLOAD: begin
            r.data_valid = 1'b1;
            r.data_out = b;
            r.data_address = hdr_offset[23:0] + 24'(i);
            crc16_run = ccitt_step(crc16_run, b);
            crc_tentative = ieee_step(crc_tentative, b);
            byte_count = i + 1;
            if (byte_count >= hdr_length) begin
              if (crc16_run != pay_check) begin
                r.status = fail_attempt();
              end else begin
                crc_committed = crc_tentative;
                bytes_received = bytes_received + 24'(hdr_length);
                next_seq++;
                attempts = 0;
                r.commit_offset = hdr_offset[23:0];
                r.commit_length = hdr_length;
                if ({8'd0, bytes_received} == image_size) begin
                  phase = PH_IDLE;
                  r.status = (~crc_committed == image_crc) ? fpr_pkg::ST_DONE
                                                           : fpr_pkg::ST_CRC_ERR;
                end else begin
                  open_header();
                  r.status = fpr_pkg::ST_ACK;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0; results = 0; acks = 0; dones = 0;
    max_image = 24'd917504; max_packet = 16'd1024; max_attempts = 4'd5;
    pkt_timeout = 16'd3000; word_timeout = 16'd5000; magic = 32'hA55A1234;
    clear_session();
  end

  // sample on each edge: config writes, accepted requests, accepted results
  always @(posedge clk_i) begin
    fpr_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", 32'(out_payload_i.status), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_payload_i.status != want.status)
            report_mismatch("status", 32'(out_payload_i.status), 32'(want.status));
          if (out_payload_i.data_valid != want.data_valid)
            report_mismatch("data_valid", 32'(out_payload_i.data_valid),
                            32'(want.data_valid));
          if (out_payload_i.data_out != want.data_out)
            report_mismatch("data_out", 32'(out_payload_i.data_out), 32'(want.data_out));
          if (out_payload_i.data_address != want.data_address)
            report_mismatch("data_address", 32'(out_payload_i.data_address),
                            32'(want.data_address));
          if (out_payload_i.commit_offset != want.commit_offset)
            report_mismatch("commit_offset", 32'(out_payload_i.commit_offset),
                            32'(want.commit_offset));
          if (out_payload_i.commit_length != want.commit_length)
            report_mismatch("commit_length", 32'(out_payload_i.commit_length),
                            32'(want.commit_length));
          if (want.status == fpr_pkg::ST_ACK) acks++;
          if (want.status == fpr_pkg::ST_DONE || want.status == fpr_pkg::ST_CRC_ERR) dones++;
        end
        results++;
      end
      if (cfg_we_i) begin
        case (fpr_pkg::reg_e'(cfg_idx_i))
          fpr_pkg::REG_MAX_IMAGE:    max_image = cfg_data_i[23:0];
          fpr_pkg::REG_MAX_PACKET:   max_packet = cfg_data_i[15:0];
          fpr_pkg::REG_MAX_ATTEMPT:  max_attempts = cfg_data_i[3:0];
          fpr_pkg::REG_PKT_TIMEOUT:  pkt_timeout = cfg_data_i[15:0];
          fpr_pkg::REG_WORD_TIMEOUT: word_timeout = cfg_data_i[15:0];
          fpr_pkg::REG_MAGIC:        magic = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_result(in_payload_i));
    end
  end

  final begin
    if (expected_results.size() != 0)
      $display("%0d results never arrived", expected_results.size());
  end
endmodule

// ----- dv/tb_top.sv -----
// Testbench top: drives sessions, configuration and handshake idling, gives the verdict.
module tb_top;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          fail_count, pending, result_count, ack_count, done_count;
  int          cycle_count;
  int          sent_count;
  int          send_idle_pct, stall_pct;
  logic        hold_off;

  fpr_stream_if #(.payload_t(fpr_pkg::in_t))  in_ch ();
  fpr_stream_if #(.payload_t(fpr_pkg::out_t)) out_ch ();

  firmware_packet_receiver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  fpr_rx_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_payload_i   (in_ch.payload),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_payload_i  (out_ch.payload),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .ack_count_o    (ack_count),
    .done_count_o   (done_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // TB-side copy of settings that shape stimulus
  logic [31:0] tb_magic;
  logic [15:0] tb_max_packet;

  // receiver side: random stall, plus a long hold-off driven from the main sequence
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // send one request; idle gaps come before it per the current phase
  task automatic send_req(fpr_pkg::kind_e k, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{kind: k, rx_byte: b};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(fpr_pkg::KIND_BYTE, b);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(fpr_pkg::reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fpr_pkg::REG_MAGIC) tb_magic = val;
    if (idx == fpr_pkg::REG_MAX_PACKET) tb_max_packet = val[15:0];
  endtask

  function automatic logic [15:0] ccitt(logic [15:0] c, logic [7:0] b);
    for (int k = 7; k >= 0; k--) c = (c[15] ^ b[k]) ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic logic [31:0] ieee(logic [31:0] c, logic [7:0] b);
    for (int k = 0; k < 8; k++) c = (c[0] ^ b[k]) ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  // one packet: header then payload; corrupt selects a fault
  // 0 clean, 1 magic, 2 header crc, 3 seq, 4 payload crc, 5 truncated payload
  task automatic send_packet(logic [31:0] seq, logic [31:0] ofs, logic [7:0] data[],
                             int corrupt);
    logic [7:0]  hdr[20];
    logic [15:0] hc, pc;
    int len;
    len = data.size();
    pc = 16'hFFFF;
    foreach (data[j]) pc = ccitt(pc, data[j]);
    if (corrupt == 4) pc = ~pc;
    for (int k = 0; k < 4; k++) begin
      hdr[k] = (corrupt == 1) ? ~tb_magic[8*k +: 8] : tb_magic[8*k +: 8];
      hdr[4 + k] = (corrupt == 3) ? seq[8*k +: 8] ^ 8'h01 : seq[8*k +: 8];
      hdr[8 + k] = ofs[8*k +: 8];
    end
    hdr[12] = len[7:0]; hdr[13] = len[15:8];
    hdr[14] = 8'd0; hdr[15] = 8'd0;
    hdr[16] = pc[7:0]; hdr[17] = pc[15:8];
    hdr[18] = 8'($urandom); hdr[19] = 8'($urandom);
    hc = 16'hFFFF;
    foreach (hdr[k]) hc = ccitt(hc, hdr[k]);
    if (corrupt == 2) hc = hc ^ 16'h8001;
    hdr[14] = hc[7:0]; hdr[15] = hc[15:8];
    foreach (hdr[k]) send_byte(hdr[k]);
    for (int k = 0; k < len - ((corrupt == 5) ? 1 : 0); k++) send_byte(data[k]);
  endtask

  // full session; faults sprinkled at rate fault_pct, ticks too
  task automatic run_session(int size, int maxpkt, int fault_pct, logic bad_crc);
    logic [7:0] img[];
    logic [7:0] chunk[];
    logic [31:0] crc;
    int ofs, seq, len, f;
    img = new[size];
    crc = '1;
    foreach (img[k]) begin
      img[k] = 8'($urandom);
      crc = ieee(crc, img[k]);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ 32'h1;
    send_req(fpr_pkg::KIND_START, 8'($urandom));
    send_word(size);
    send_word(crc);
    ofs = 0; seq = 0;
    while (ofs < size) begin
      len = $urandom_range(1, (size - ofs < maxpkt) ? size - ofs : maxpkt);
      chunk = new[len];
      foreach (chunk[k]) chunk[k] = img[ofs + k];
      f = ($urandom_range(99) < fault_pct) ? $urandom_range(1, 4) : 0;
      if ($urandom_range(9) == 0) send_req(fpr_pkg::KIND_TICK, 8'($urandom));
      send_packet(seq, ofs, chunk, f);
      if (f == 0) begin
        ofs += len; seq++;
      end
    end
  endtask

  logic [7:0] one_byte[];

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.payload = '0;
    hold_off = 1'b0;
    sent_count = 0;
    send_idle_pct = 0; stall_pct = 0;
    tb_magic = 32'hA55A1234; tb_max_packet = 16'd1024;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle items, kind three, size errors, word timeout
    write_reg(fpr_pkg::REG_MAX_ATTEMPT, 32'd2);
    write_reg(fpr_pkg::REG_WORD_TIMEOUT, 32'd2);
    write_reg(fpr_pkg::REG_PKT_TIMEOUT, 32'd1);
    write_reg(fpr_pkg::REG_MAX_IMAGE, 32'hFFFFFF);
    write_reg(fpr_pkg::REG_MAX_PACKET, 32'hFFFF);
    write_reg(fpr_pkg::REG_MAGIC, 32'hFFFFFFFF);
    send_byte(8'hFF); send_req(fpr_pkg::KIND_TICK, 8'd0);
    send_req(fpr_pkg::KIND_NONE, 8'h00);
    send_req(fpr_pkg::KIND_START, 8'd0); send_word(32'd0); send_word(32'hFFFFFFFF);
    send_req(fpr_pkg::KIND_START, 8'd0); send_req(fpr_pkg::KIND_TICK, 8'd0);
    send_req(fpr_pkg::KIND_TICK, 8'd0);
    send_req(fpr_pkg::KIND_START, 8'd0); send_byte(8'h01); send_byte(8'd0);
    send_byte(8'd0); send_byte(8'd0);
    send_req(fpr_pkg::KIND_TICK, 8'd0); send_req(fpr_pkg::KIND_TICK, 8'd0);
    wait_drained();
    write_reg(fpr_pkg::REG_MAX_IMAGE, 32'd1);
    write_reg(fpr_pkg::REG_WORD_TIMEOUT, 32'hFFFF);
    send_req(fpr_pkg::KIND_START, 8'd0); send_word(32'd2); send_word(32'd0);
    // one-byte image, done and crc error; then packet timeout and retry exhaustion
    one_byte = new[1]; one_byte[0] = 8'hA5;
    run_session(1, 1, 0, 1'b0);
    run_session(1, 1, 0, 1'b1);
    send_req(fpr_pkg::KIND_START, 8'd0); send_word(32'd1); send_word(32'd0);
    send_req(fpr_pkg::KIND_TICK, 8'd0); send_req(fpr_pkg::KIND_TICK, 8'd0);
    wait_drained();
    write_reg(fpr_pkg::REG_MAX_ATTEMPT, 32'd0);
    write_reg(fpr_pkg::REG_PKT_TIMEOUT, 32'd0);
    send_req(fpr_pkg::KIND_START, 8'd0); send_word(32'd1); send_word(32'd0);
    send_req(fpr_pkg::KIND_TICK, 8'd0);
    send_packet(32'd0, 32'd0, one_byte, 0);
    wait_drained();

    // random phases, several settings
    write_reg(fpr_pkg::REG_MAX_ATTEMPT, 32'd15);
    write_reg(fpr_pkg::REG_PKT_TIMEOUT, 32'hFFFF);
    write_reg(fpr_pkg::REG_WORD_TIMEOUT, 32'd5000);
    write_reg(fpr_pkg::REG_MAX_IMAGE, 32'd917504);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      write_reg(fpr_pkg::REG_MAGIC, (ph == 3) ? 32'd0 : $urandom);
      write_reg(fpr_pkg::REG_MAX_PACKET, (ph == 5) ? 32'd1 : 32'($urandom_range(2, 24)));
      if (ph == 2) begin
        // long receiver hold-off while sending continues
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      run_session($urandom_range(1, 8), int'(tb_max_packet), 15, $urandom_range(4) == 0);
      // noise: stray starts, bytes, ticks and kind three
      for (int n = 0; n < 3; n++)
        send_req(fpr_pkg::kind_e'($urandom_range(3)), 8'($urandom));
      wait_drained();
    end

    // end: drain, idle, then give the verdict
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results, %0d acks, %0d image ends",
             sent_count, result_count, ack_count, done_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- firmware_packet_receiver.f -----
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_stream_if.sv
hw/rtl/fpr_cfg_regs.sv
hw/rtl/fpr_core.sv
hw/rtl/firmware_packet_receiver.sv
hw/rtl/fpr_checker.sv
dv/fpr_rx_checker.sv
dv/tb_top.sv
